/* design/ampd_pkg.sv */
package ampd_pkg;

  localparam int TICK_W = 16;
  localparam int SYNC_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int END_BITS = 40;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_V3   = 4'b0010,
    M_HELD = 4'b0100,
    M_V2   = 4'b1000
  } rx_mode_t;

  typedef struct packed {
    logic done;
    logic is_short;
    logic is_long;
  } period_class_t;

  localparam logic [1:0] FUNC_EDGE    = 2'd0;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  localparam logic [1:0] VER_NONE = 2'd0;
  localparam logic [1:0] VER_V2   = 2'd2;
  localparam logic [1:0] VER_V3   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ON_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ON_SPLIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ON_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_SPLIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_MAX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_SYNC = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_SYNC  = 3'd7;

  localparam logic [TICK_W-1:0] ON_MIN_RST    = 16'd50;
  localparam logic [TICK_W-1:0] ON_SPLIT_RST  = 16'd137;
  localparam logic [TICK_W-1:0] ON_MAX_RST    = 16'd275;
  localparam logic [TICK_W-1:0] OFF_MIN_RST   = 16'd100;
  localparam logic [TICK_W-1:0] OFF_SPLIT_RST = 16'd212;
  localparam logic [TICK_W-1:0] OFF_MAX_RST   = 16'd350;
  localparam logic [SYNC_W-1:0] SHORT_SYNC_RST = 8'd20;
  localparam logic [SYNC_W-1:0] LONG_SYNC_RST  = 8'd25;

endpackage

/* design/ampd_period_class.sv */
module ampd_period_class
  import ampd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TICK_W-1:0] period_in,
  input  logic [TICK_W-1:0] lo,
  input  logic [TICK_W-1:0] split,
  input  logic [TICK_W-1:0] hi,
  output period_class_t     cls
);

  logic [TICK_W-1:0] period;
  logic [1:0]        step;
  logic              run;
  logic              ge_lo;
  logic              le_split;
  logic [TICK_W-1:0] opa;
  logic [TICK_W-1:0] opb;
  logic              le;

  // One shared comparator walks the three thresholds in turn.
  always_comb begin
    case (step)
      2'd0: begin
        opa = lo;
        opb = period;
      end
      2'd1: begin
        opa = period;
        opb = split;
      end
      2'd2: begin
        opa = period;
        opb = hi;
      end
      default: begin
        opa = lo;
        opb = period;
      end
    endcase
  end

  assign le = (opa <= opb);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      step <= 2'd0;
      cls <= '0;
    end else begin
      cls.done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        step <= 2'd0;
        period <= period_in;
      end else if (run) begin
        case (step)
          2'd0: begin
            ge_lo <= le;
            step <= 2'd1;
          end
          2'd1: begin
            le_split <= le;
            step <= 2'd2;
          end
          default: begin
            cls.done <= 1'b1;
            cls.is_short <= ge_lo & le_split;
            cls.is_long <= ~le_split & le;
            run <= 1'b0;
            step <= 2'd0;
          end
        endcase
      end
    end
  end

endmodule

/* design/ask_manchester_pulse_decoder_unit.sv */
// Manchester ASK pulse-width decoder for version 2.1 and version 3 radio messages.
// Requests arrive on the in_valid/in_ready channel: an edge event (capture time,
// timer wraps, carrier level), a silence timeout, or a release of a held message.
// Decoded messages leave on the out_valid/out_ready channel as one nibble per
// transfer, first nibble first, with is_last set on the final one.
// An edge request keeps in_ready low while the period is formed and registered,
// the single shared comparator checks it against the minimum, split and maximum
// thresholds in turn, and the decoder state is updated from the result.
// Timeout, release and unused requests leave in_ready high unless readout starts.
// Readout walks the nibble store one nibble at a time, with a registered memory
// read followed by a load of the output register; in_ready stays low
// until the last nibble sits in the output register.
// When the receiver stalls, readout waits with the next nibble in hand.
// Reset returns the decoder to idle and loads the default thresholds; the
// nibble store is not cleared, since every nibble read out has been written.
// Thresholds must be written on the cfg port while idle; the block does not check.
module ask_manchester_pulse_decoder_unit
  import ampd_pkg::*;
#(
  parameter int MAX_NIBBLES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           func,
  input  logic [TICK_W-1:0]    capture_time,
  input  logic [TICK_W-1:0]    wraps_since_last,
  input  logic                 carrier_was_on,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           nibble,
  output logic [5:0]           nibble_index,
  output logic [1:0]           protocol_version,
  output logic                 is_last
);

  localparam int BW = $clog2(MAX_NIBBLES * 4 + 1);
  localparam int AW = $clog2(MAX_NIBBLES);
  localparam int CW = $clog2(MAX_NIBBLES + 1);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_CLASS    = 4'b0010,
    S_EMIT_RD  = 4'b0100,
    S_EMIT_OUT = 4'b1000
  } seq_state_t;

  seq_state_t state;

  logic [TICK_W-1:0] on_min, on_split, on_max, off_min, off_split, off_max;
  logic [SYNC_W-1:0] short_sync, long_sync;

  rx_mode_t          rx_mode, rx_mode_next;
  logic [TICK_W-1:0] short_seen, short_seen_next;
  logic [TICK_W-1:0] long_seen, long_seen_next;
  logic [1:0]        version_held, version_held_next;
  logic [BW-1:0]     bit_pointer, bit_pointer_next;
  logic [TICK_W-1:0] last_capture;
  logic              bit_value, bit_value_next;
  logic              half_short_pending, half_short_pending_next;
  logic              skip_repeat, skip_repeat_next;
  logic              was_on;
  logic [3:0]        asm_nib;

  logic              st_en, st_val, init_wr, go_emit, dec_rst;
  logic [3:0]        st_nib;

  logic [3:0]        mem [MAX_NIBBLES];
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [3:0]        mem_wd;
  logic [3:0]        nib_rd;

  logic [CW-1:0]     emit_cnt, emit_idx;
  logic              emit_last;
  logic              out_load;
  logic [BW:0]       bp_round;

  logic              accept;
  logic              receiving;
  logic              timeout_hit;
  logic [TICK_W-1:0] period_in;
  period_class_t     cls;

  assign accept = in_valid & in_ready;
  assign in_ready = (state == S_IDLE);
  assign receiving = (rx_mode == M_V2) || (rx_mode == M_V3);
  assign timeout_hit = receiving && (bit_pointer > BW'(END_BITS));
  assign period_in = (wraps_since_last > 16'd1) ? 16'hFFFF : (capture_time - last_capture);
  assign bp_round = {1'b0, bit_pointer} + (BW + 1)'(3);
  assign emit_last = ((emit_idx + CW'(1)) == emit_cnt);
  assign out_load = (state == S_EMIT_OUT) && (!out_valid || out_ready);

  ampd_period_class u_class (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && (func == FUNC_EDGE)),
    .period_in (period_in),
    .lo        (was_on ? on_min : off_min),
    .split     (was_on ? on_split : off_split),
    .hi        (was_on ? on_max : off_max),
    .cls       (cls)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      on_min <= ON_MIN_RST;
      on_split <= ON_SPLIT_RST;
      on_max <= ON_MAX_RST;
      off_min <= OFF_MIN_RST;
      off_split <= OFF_SPLIT_RST;
      off_max <= OFF_MAX_RST;
      short_sync <= SHORT_SYNC_RST;
      long_sync <= LONG_SYNC_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ON_MIN:     on_min <= cfg_data;
        REG_ON_SPLIT:   on_split <= cfg_data;
        REG_ON_MAX:     on_max <= cfg_data;
        REG_OFF_MIN:    off_min <= cfg_data;
        REG_OFF_SPLIT:  off_split <= cfg_data;
        REG_OFF_MAX:    off_max <= cfg_data;
        REG_SHORT_SYNC: short_sync <= cfg_data[SYNC_W-1:0];
        REG_LONG_SYNC:  long_sync <= cfg_data[SYNC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rx_mode_next = rx_mode;
    short_seen_next = short_seen;
    long_seen_next = long_seen;
    version_held_next = version_held;
    bit_pointer_next = bit_pointer;
    bit_value_next = bit_value;
    half_short_pending_next = half_short_pending;
    skip_repeat_next = skip_repeat;
    st_en = 1'b0;
    st_val = 1'b0;
    init_wr = 1'b0;
    go_emit = 1'b0;
    dec_rst = 1'b0;
    case (rx_mode)
      M_IDLE: begin
        if (cls.is_short) begin
          if (short_seen <= 16'd1 && long_seen > {8'd0, long_sync}) begin
            version_held_next = VER_V2;
            skip_repeat_next = 1'b0;
            rx_mode_next = M_V2;
            half_short_pending_next = 1'b1;
            bit_pointer_next = '0;
            init_wr = 1'b1;
            bit_value_next = 1'b1;
          end else if (long_seen == 16'd0) begin
            if (short_seen != 16'hFFFF) begin
              short_seen_next = short_seen + 16'd1;
            end
          end else begin
            dec_rst = 1'b1;
          end
        end else if (cls.is_long) begin
          if (short_seen > {8'd0, short_sync}) begin
            rx_mode_next = M_V3;
            version_held_next = VER_V3;
            half_short_pending_next = 1'b0;
            bit_pointer_next = BW'(1);
            init_wr = 1'b1;
            bit_value_next = 1'b0;
          end else if (short_seen <= 16'd1) begin
            if (long_seen != 16'hFFFF) begin
              long_seen_next = long_seen + 16'd1;
            end
          end else begin
            dec_rst = 1'b1;
          end
        end else begin
          dec_rst = 1'b1;
        end
      end
      M_V3: begin
        if (cls.is_short) begin
          if (half_short_pending) begin
            st_en = 1'b1;
            st_val = bit_value;
            half_short_pending_next = 1'b0;
          end else begin
            half_short_pending_next = 1'b1;
          end
        end else if (cls.is_long) begin
          if (half_short_pending) begin
            dec_rst = 1'b1;
          end else begin
            bit_value_next = ~bit_value;
            st_en = 1'b1;
            st_val = ~bit_value;
          end
        end else if (bit_pointer > BW'(END_BITS)) begin
          rx_mode_next = M_HELD;
          go_emit = 1'b1;
        end else begin
          dec_rst = 1'b1;
        end
      end
      M_V2: begin
        if (cls.is_short) begin
          if (half_short_pending) begin
            bit_value_next = ~bit_value;
            if (skip_repeat) begin
              dec_rst = 1'b1;
            end else begin
              st_en = 1'b1;
              st_val = ~bit_value;
              skip_repeat_next = 1'b1;
            end
            half_short_pending_next = 1'b0;
          end else begin
            half_short_pending_next = 1'b1;
          end
        end else if (cls.is_long) begin
          if (half_short_pending) begin
            dec_rst = 1'b1;
          end else if (skip_repeat) begin
            skip_repeat_next = 1'b0;
          end else begin
            st_en = 1'b1;
            st_val = bit_value;
            skip_repeat_next = 1'b1;
          end
        end else if (bit_pointer > BW'(END_BITS)) begin
          rx_mode_next = M_HELD;
          go_emit = 1'b1;
        end else begin
          dec_rst = 1'b1;
        end
      end
      default: ;
    endcase
    if (st_en) begin
      bit_pointer_next = bit_pointer + BW'(1);
    end
    if (dec_rst || bit_pointer_next >= BW'(MAX_NIBBLES * 4)) begin
      version_held_next = VER_NONE;
      short_seen_next = '0;
      long_seen_next = '0;
      rx_mode_next = M_IDLE;
      bit_pointer_next = '0;
      go_emit = 1'b0;
    end
  end

  always_comb begin
    st_nib = (bit_pointer[1:0] == 2'd0) ? 4'd0 : asm_nib;
    st_nib[bit_pointer[1:0]] = st_val;
  end

  assign mem_we = cls.done && (st_en || init_wr);
  assign mem_wa = init_wr ? '0 : AW'(bit_pointer >> 2);
  assign mem_wd = init_wr ? 4'd0 : st_nib;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
      asm_nib <= mem_wd;
    end
    if (state == S_EMIT_RD) begin
      nib_rd <= mem[emit_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rx_mode <= M_IDLE;
      short_seen <= '0;
      long_seen <= '0;
      version_held <= VER_NONE;
      bit_pointer <= '0;
      last_capture <= '0;
      bit_value <= 1'b0;
      half_short_pending <= 1'b0;
      skip_repeat <= 1'b0;
      out_valid <= 1'b0;
      emit_idx <= '0;
      emit_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (func)
              FUNC_EDGE: begin
                last_capture <= capture_time;
                was_on <= carrier_was_on;
                state <= S_CLASS;
              end
              FUNC_TIMEOUT: begin
                if (timeout_hit) begin
                  rx_mode <= M_HELD;
                  emit_idx <= '0;
                  emit_cnt <= CW'(bp_round >> 2);
                  state <= S_EMIT_RD;
                end
              end
              FUNC_RELEASE: begin
                if (rx_mode == M_HELD) begin
                  version_held <= VER_NONE;
                  short_seen <= '0;
                  long_seen <= '0;
                  rx_mode <= M_IDLE;
                  bit_pointer <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_CLASS: begin
          if (cls.done) begin
            rx_mode <= rx_mode_next;
            short_seen <= short_seen_next;
            long_seen <= long_seen_next;
            version_held <= version_held_next;
            bit_pointer <= bit_pointer_next;
            bit_value <= bit_value_next;
            half_short_pending <= half_short_pending_next;
            skip_repeat <= skip_repeat_next;
            emit_idx <= '0;
            emit_cnt <= CW'(bp_round >> 2);
            state <= go_emit ? S_EMIT_RD : S_IDLE;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (out_load) begin
            emit_idx <= emit_idx + CW'(1);
            state <= emit_last ? S_IDLE : S_EMIT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      nibble <= nib_rd;
      nibble_index <= 6'(emit_idx);
      protocol_version <= version_held;
      is_last <= emit_last;
    end
  end

  a_bp_range: assert property (@(posedge clk) disable iff (rst)
    bit_pointer < BW'(MAX_NIBBLES * 4))
    else $error("bit pointer reached the end of the nibble store");

  a_emit_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_RD || state == S_EMIT_OUT) |-> rx_mode == M_HELD)
    else $error("readout running while no message is held");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    out_load && emit_last |=> out_valid && is_last && state == S_IDLE)
    else $error("final nibble did not close the readout");

  a_class_state: assert property (@(posedge clk) disable iff (rst)
    cls.done |-> state == S_CLASS)
    else $error("period class arrived outside of an edge request");

  a_version: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (protocol_version == VER_V2 || protocol_version == VER_V3))
    else $error("nibble sent with no protocol version");

endmodule

/* tb/tb.sv */
module tb;
  import ampd_pkg::*;

  localparam int NIB_DEPTH = 32;
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef enum logic [1:0] {
    CLS_SHORT,
    CLS_LONG,
    CLS_BAD
  } period_cls_t;

  typedef struct packed {
    logic [3:0] nib;
    logic [5:0] idx;
    logic [1:0] ver;
    logic       last;
  } nibble_rec_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TICK_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           func;
  logic [TICK_W-1:0]    capture_time;
  logic [TICK_W-1:0]    wraps_since_last;
  logic                 carrier_was_on;
  logic                 out_valid;
  logic                 out_ready;
  logic [3:0]           nibble;
  logic [5:0]           nibble_index;
  logic [1:0]           protocol_version;
  logic                 is_last;

  ask_manchester_pulse_decoder_unit #(.MAX_NIBBLES(NIB_DEPTH)) dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .capture_time(capture_time), .wraps_since_last(wraps_since_last),
    .carrier_was_on(carrier_was_on), .out_valid(out_valid), .out_ready(out_ready),
    .nibble(nibble), .nibble_index(nibble_index), .protocol_version(protocol_version),
    .is_last(is_last)
  );

  // Decoder shadow state and register copy.
  logic [15:0] thr [8];
  rx_mode_t    dec_mode;
  logic [15:0] n_short;
  logic [15:0] n_long;
  logic [1:0]  ver;
  logic [7:0]  bitpos;
  logic [15:0] prev_cap;
  logic        cur_bit;
  logic        half_pend;
  logic        skip_next;
  logic [3:0]  nib_mem [NIB_DEPTH];

  nibble_rec_t expected_nibbles [$];
  nibble_rec_t got_rec;
  nibble_rec_t want_rec;

  int  fails = 0;
  int  cycles = 0;
  int  counted = 0;
  int  hold_cnt = 0;
  int  rx_gap = 0;
  bit  pace_on = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_rec = '{nib: nibble, idx: nibble_index, ver: protocol_version, last: is_last};
      if (expected_nibbles.size() == 0) begin
        fails++;
        $display("%0t: expected no nibble, got %h idx %0d ver %0d last %0b", $time,
                 nibble, nibble_index, protocol_version, is_last);
      end else begin
        want_rec = expected_nibbles.pop_front();
        if (got_rec !== want_rec) begin
          fails++;
          $display("%0t: expected %h idx %0d ver %0d last %0b, got %h idx %0d ver %0d last %0b",
                   $time, want_rec.nib, want_rec.idx, want_rec.ver, want_rec.last,
                   nibble, nibble_index, protocol_version, is_last);
        end
      end
      rx_gap = pace_on ? $urandom_range(0, 11) : 0;
    end
  end

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

  function automatic period_cls_t classify(input logic [15:0] p, input logic on);
    logic [15:0] lo, sp, hi;
    lo = on ? thr[REG_ON_MIN] : thr[REG_OFF_MIN];
    sp = on ? thr[REG_ON_SPLIT] : thr[REG_OFF_SPLIT];
    hi = on ? thr[REG_ON_MAX] : thr[REG_OFF_MAX];
    if (p >= lo && p <= sp) return CLS_SHORT;
    if (p > sp && p <= hi) return CLS_LONG;
    return CLS_BAD;
  endfunction

  task automatic clear_decoder();
    ver = VER_NONE;
    n_short = '0;
    n_long = '0;
    dec_mode = M_IDLE;
    bitpos = '0;
  endtask

  task automatic store_bit(input logic b);
    logic [3:0] v;
    if (int'(bitpos[7:2]) < NIB_DEPTH) begin
      v = (bitpos[1:0] == 2'd0) ? 4'd0 : nib_mem[bitpos[7:2]];
      v[bitpos[1:0]] = b;
      nib_mem[bitpos[7:2]] = v;
    end
    bitpos = bitpos + 8'd1;
  endtask

  task automatic emit_message();
    int cnt;
    int k;
    nibble_rec_t r;
    cnt = (int'(bitpos) + 3) >> 2;
    if (cnt > NIB_DEPTH) cnt = NIB_DEPTH;
    for (k = 0; k < cnt; k++) begin
      r.nib = nib_mem[k];
      r.idx = k[5:0];
      r.ver = ver;
      r.last = (k + 1 == cnt);
      expected_nibbles.push_back(r);
    end
  endtask

  task automatic apply_edge(input logic [15:0] cap, input logic [15:0] wr, input logic on);
    logic [15:0] period;
    period_cls_t c;
    period = (wr > 16'd1) ? 16'hFFFF : cap - prev_cap;
    c = classify(period, on);
    case (dec_mode)
      M_IDLE: begin
        if (c == CLS_SHORT) begin
          if (n_short <= 16'd1 && n_long > thr[REG_LONG_SYNC]) begin
            ver = VER_V2;
            skip_next = 1'b0;
            dec_mode = M_V2;
            half_pend = 1'b1;
            bitpos = '0;
            nib_mem[0] = 4'd0;
            cur_bit = 1'b1;
          end else if (n_long == 16'd0) begin
            n_short = sat_inc(n_short);
          end else begin
            clear_decoder();
          end
        end else if (c == CLS_LONG) begin
          if (n_short > thr[REG_SHORT_SYNC]) begin
            dec_mode = M_V3;
            ver = VER_V3;
            half_pend = 1'b0;
            bitpos = 8'd1;
            nib_mem[0] = 4'd0;
            cur_bit = 1'b0;
          end else if (n_short <= 16'd1) begin
            n_long = sat_inc(n_long);
          end else begin
            clear_decoder();
          end
        end else begin
          clear_decoder();
        end
      end
      M_V3: begin
        if (c == CLS_SHORT) begin
          if (half_pend) store_bit(cur_bit);
          half_pend = !half_pend;
        end else if (c == CLS_LONG) begin
          if (half_pend) begin
            clear_decoder();
          end else begin
            cur_bit = !cur_bit;
            store_bit(cur_bit);
          end
        end else if (bitpos > END_BITS) begin
          dec_mode = M_HELD;
        end else begin
          clear_decoder();
        end
      end
      M_V2: begin
        if (c == CLS_SHORT) begin
          if (half_pend) begin
            cur_bit = !cur_bit;
            if (skip_next) begin
              clear_decoder();
            end else begin
              store_bit(cur_bit);
              skip_next = 1'b1;
            end
            half_pend = 1'b0;
          end else begin
            half_pend = 1'b1;
          end
        end else if (c == CLS_LONG) begin
          if (half_pend) begin
            clear_decoder();
          end else if (skip_next) begin
            skip_next = 1'b0;
          end else begin
            store_bit(cur_bit);
            skip_next = 1'b1;
          end
        end else if (bitpos > END_BITS) begin
          dec_mode = M_HELD;
        end else begin
          clear_decoder();
        end
      end
      default: ;
    endcase
    prev_cap = cap;
    if (int'(bitpos) >= NIB_DEPTH * 4) clear_decoder();
  endtask

  task automatic decode_request(input logic [1:0] f, input logic [15:0] cap,
                                input logic [15:0] wr, input logic on, output bit ignored);
    bit rcv;
    rcv = (dec_mode == M_V2 || dec_mode == M_V3);
    ignored = 1'b0;
    case (f)
      FUNC_EDGE: begin
        apply_edge(cap, wr, on);
        if (rcv && dec_mode == M_HELD) emit_message();
      end
      FUNC_TIMEOUT: begin
        if (rcv && bitpos > END_BITS) begin
          dec_mode = M_HELD;
          emit_message();
        end else begin
          ignored = 1'b1;
        end
      end
      FUNC_RELEASE: begin
        if (dec_mode == M_HELD) clear_decoder();
        else ignored = 1'b1;
      end
      default: ignored = 1'b1;
    endcase
  endtask

  function automatic logic [15:0] rand16();
    return $urandom_range(0, 65535);
  endfunction

  function automatic logic [15:0] pick_wraps();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'd1;
      2: return $urandom_range(2, 65535);
      default: return $urandom_range(0, 1);
    endcase
  endfunction

  function automatic bit pick_period(input period_cls_t want, input logic on,
                                     output logic [15:0] p, output logic [15:0] w);
    int lo, sp, hi;
    lo = on ? thr[REG_ON_MIN] : thr[REG_OFF_MIN];
    sp = on ? thr[REG_ON_SPLIT] : thr[REG_OFF_SPLIT];
    hi = on ? thr[REG_ON_MAX] : thr[REG_OFF_MAX];
    w = $urandom_range(0, 1);
    p = 16'd0;
    case (want)
      CLS_SHORT: begin
        if (lo > sp) return 1'b0;
        p = $urandom_range(lo, sp);
      end
      CLS_LONG: begin
        if (sp >= hi) return 1'b0;
        p = $urandom_range(sp + 1, hi);
      end
      default: begin
        case ($urandom_range(0, 2))
          0: begin
            p = 16'hFFFF;
            w = $urandom_range(2, 65535);
          end
          1: if (lo > 0) p = $urandom_range(0, lo - 1);
          default: if (hi < 65535) p = $urandom_range(hi + 1, 65535);
        endcase
      end
    endcase
    return classify(p, on) == want;
  endfunction

  task automatic send_req(input logic [1:0] f, input logic [15:0] cap,
                          input logic [15:0] wr, input logic on);
    int g;
    bit ign;
    func <= f;
    capture_time <= cap;
    wraps_since_last <= wr;
    carrier_was_on <= on;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_request(f, cap, wr, on, ign);
    if (!ign) counted++;
    @(negedge clk);
    g = pace_on ? $urandom_range(0, 11) : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic send_symbol(input period_cls_t want, output bit ok);
    logic        on;
    logic [15:0] p, w;
    int          tries;
    ok = 1'b0;
    for (tries = 0; tries < 8 && !ok; tries++) begin
      on = $urandom_range(0, 1);
      ok = pick_period(want, on, p, w);
    end
    if (ok) send_req(FUNC_EDGE, (w > 16'd1) ? rand16() : prev_cap + p, w, on);
  endtask

  task automatic send_noise();
    send_req(2'($urandom_range(0, 3)), rand16(), pick_wraps(), 1'($urandom_range(0, 1)));
  endtask

  task automatic stop_requests();
    in_valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    stop_requests();
    while (expected_nibbles.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic program_regs(input logic [15:0] on_lo, on_sp, on_hi,
                              input logic [15:0] off_lo, off_sp, off_hi,
                              input logic [7:0] s_sync, l_sync);
    logic [15:0] v [8];
    int i;
    v[REG_ON_MIN] = on_lo;
    v[REG_ON_SPLIT] = on_sp;
    v[REG_ON_MAX] = on_hi;
    v[REG_OFF_MIN] = off_lo;
    v[REG_OFF_SPLIT] = off_sp;
    v[REG_OFF_MAX] = off_hi;
    v[REG_SHORT_SYNC] = {8'($urandom_range(0, 255)), s_sync};
    v[REG_LONG_SYNC] = {8'($urandom_range(0, 255)), l_sync};
    wait_quiet();
    for (i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= v[i];
      thr[i] = (i >= REG_SHORT_SYNC) ? {8'h00, v[i][7:0]} : v[i];
      @(negedge clk);
    end
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle_decoder();
    int tries;
    bit ok;
    tries = 0;
    while (tries < 8 && !(dec_mode == M_IDLE && n_short == 0 && n_long == 0)) begin
      if (dec_mode == M_HELD) send_req(FUNC_RELEASE, rand16(), pick_wraps(), 1'b0);
      else send_symbol(CLS_BAD, ok);
      tries++;
    end
  endtask

  // A preamble followed by legal Manchester symbols; err_rate > 0 mixes in
  // random symbols that may break the message.
  task automatic send_message(input logic [1:0] version, input int target,
                              input int err_rate, input bit press);
    int n;
    bit ok;
    period_cls_t want;
    settle_decoder();
    if (version == VER_V3) begin
      n = thr[REG_SHORT_SYNC] + 1 + $urandom_range(0, 2);
      repeat (n) send_symbol(CLS_SHORT, ok);
      send_symbol(CLS_LONG, ok);
    end else begin
      n = thr[REG_LONG_SYNC] + 1 + $urandom_range(0, 2);
      repeat (n) send_symbol(CLS_LONG, ok);
      send_symbol(CLS_SHORT, ok);
    end
    while ((dec_mode == M_V2 || dec_mode == M_V3) && int'(bitpos) < target) begin
      if (err_rate > 0 && $urandom_range(1, err_rate) == 1)
        want = period_cls_t'($urandom_range(0, 2));
      else if (half_pend)
        want = CLS_SHORT;
      else if (dec_mode == M_V2 && skip_next)
        want = CLS_LONG;
      else
        want = $urandom_range(0, 1) ? CLS_SHORT : CLS_LONG;
      send_symbol(want, ok);
      if (!ok) break;
    end
    if (dec_mode == M_V2 || dec_mode == M_V3) begin
      if (press) hold_cnt = 300;
      if ($urandom_range(0, 1)) send_req(FUNC_TIMEOUT, rand16(), pick_wraps(), 1'b1);
      else send_symbol(CLS_BAD, ok);
    end
    repeat ($urandom_range(0, 2)) send_symbol(period_cls_t'($urandom_range(0, 2)), ok);
    if ($urandom_range(0, 3) != 0) send_req(FUNC_RELEASE, rand16(), pick_wraps(), 1'b1);
  endtask

  task automatic test_directed();
    bit ok;
    send_req(FUNC_RELEASE, 16'h0000, 16'h0000, 1'b0);
    send_req(FUNC_TIMEOUT, 16'hFFFF, 16'hFFFF, 1'b1);
    send_req(FUNC_SPARE, 16'hFFFF, 16'hFFFF, 1'b1);
    send_req(FUNC_SPARE, 16'h0000, 16'h0000, 1'b0);
    send_req(FUNC_EDGE, 16'h0000, 16'h0000, 1'b0);
    send_req(FUNC_EDGE, 16'hFFFF, 16'h0001, 1'b1);
    send_req(FUNC_EDGE, 16'h1234, 16'hFFFF, 1'b0);
    program_regs(ON_MIN_RST, ON_SPLIT_RST, ON_MAX_RST,
                 OFF_MIN_RST, OFF_SPLIT_RST, OFF_MAX_RST, 8'd0, 8'd0);
    // Version 3: a long period right after a single short one.
    send_symbol(CLS_SHORT, ok);
    send_symbol(CLS_LONG, ok);
    send_symbol(CLS_SHORT, ok);
    send_symbol(CLS_LONG, ok);
    // A timeout with too few bits is ignored; the invalid period then resets.
    send_symbol(CLS_SHORT, ok);
    send_symbol(CLS_LONG, ok);
    send_req(FUNC_TIMEOUT, 16'h0000, 16'h0000, 1'b0);
    send_symbol(CLS_BAD, ok);
    // Version 2.1: two short pairs in a row.
    send_symbol(CLS_LONG, ok);
    repeat (4) send_symbol(CLS_SHORT, ok);
    // Version 2.1: a long period after a single short one.
    send_symbol(CLS_LONG, ok);
    send_symbol(CLS_SHORT, ok);
    send_symbol(CLS_LONG, ok);
  endtask

  task automatic test_messages();
    program_regs(ON_MIN_RST, ON_SPLIT_RST, ON_MAX_RST,
                 OFF_MIN_RST, OFF_SPLIT_RST, OFF_MAX_RST, SHORT_SYNC_RST, LONG_SYNC_RST);
    send_message(VER_V3, 44, 0, 1'b0);
    send_message(VER_V2, 44, 0, 1'b0);
    program_regs(ON_MIN_RST, ON_SPLIT_RST, ON_MAX_RST,
                 OFF_MIN_RST, OFF_SPLIT_RST, OFF_MAX_RST, 8'd1, 8'd2);
    send_message(VER_V3, NIB_DEPTH * 4, 0, 1'b0);
    send_message(VER_V2, NIB_DEPTH * 4 - 1, 0, 1'b0);
    send_message(VER_V3, 60, 0, 1'b1);
    pace_on = 1'b0;
    send_message(VER_V2, 50, 0, 1'b0);
    pace_on = 1'b1;
  endtask

  task automatic test_extreme_regs();
    program_regs(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0);
    send_message(VER_V3, 45, 0, 1'b0);
    send_message(VER_V2, 45, 0, 1'b0);
    repeat (10) send_noise();
    program_regs(16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 16'hFFFF, 8'hFF, 8'hFF);
    repeat (30) send_noise();
  endtask

  task automatic test_random_traffic();
    int phase;
    int goal;
    logic [15:0] a, b, c, d, e, f;
    for (phase = 0; phase < 4; phase++) begin
      a = $urandom_range(0, 200);
      b = a + $urandom_range(0, 200);
      c = b + $urandom_range(1, 300);
      d = $urandom_range(0, 200);
      e = d + $urandom_range(0, 200);
      f = e + $urandom_range(1, 300);
      if ($urandom_range(0, 3) == 0) begin
        d = rand16();
        e = rand16();
        f = rand16();
      end
      program_regs(a, b, c, d, e, f, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
      goal = counted + 105;
      while (counted < goal) begin
        pace_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 9) < 7)
          send_message($urandom_range(0, 1) ? VER_V3 : VER_V2,
                       ($urandom_range(0, 5) == 0) ? $urandom_range(0, 40)
                                                   : $urandom_range(41, 72),
                       ($urandom_range(0, 2) == 0) ? 30 : 0, 1'b0);
        else
          repeat ($urandom_range(1, 6)) send_noise();
      end
    end
    pace_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    func = FUNC_EDGE;
    capture_time = '0;
    wraps_since_last = '0;
    carrier_was_on = 1'b0;
    out_ready = 1'b0;
    thr[REG_ON_MIN] = ON_MIN_RST;
    thr[REG_ON_SPLIT] = ON_SPLIT_RST;
    thr[REG_ON_MAX] = ON_MAX_RST;
    thr[REG_OFF_MIN] = OFF_MIN_RST;
    thr[REG_OFF_SPLIT] = OFF_SPLIT_RST;
    thr[REG_OFF_MAX] = OFF_MAX_RST;
    thr[REG_SHORT_SYNC] = {8'h00, SHORT_SYNC_RST};
    thr[REG_LONG_SYNC] = {8'h00, LONG_SYNC_RST};
    foreach (nib_mem[i]) nib_mem[i] = 4'd0;
    clear_decoder();
    prev_cap = '0;
    cur_bit = 1'b0;
    half_pend = 1'b0;
    skip_next = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_messages();
    test_extreme_regs();
    test_random_traffic();
    stop_requests();
    while (expected_nibbles.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

/* ask_manchester_pulse_decoder_unit.f */
design/ampd_pkg.sv
design/ampd_period_class.sv
design/ask_manchester_pulse_decoder_unit.sv
tb/tb.sv
